// File: rtl/core/nca_pkg.sv
// Shared types and constants for the nearest-centroid assignment block.
// Used by nca_front, nca_back and nearest_centroid_assign_top; no dependencies.
package nca_pkg;

  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_FEATURES = 16;

  // Index fields in the command queue are sized for the largest parameter values.
  localparam int IDX_W  = 8;
  localparam int VAL_W  = 16;
  localparam int ACC_W  = 48;
  localparam int WCSS_W = 63;
  localparam int CFG_W  = 5;
  localparam int QDEPTH = 2;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] csel;
    logic [IDX_W-1:0] fsel;
    logic [VAL_W-1:0] value;
    logic             add;
    logic             last;
  } cmd_t;

endpackage

// File: rtl/core/nca_front.sv
// Front end: accepts requests, drops those with no effect, queues the rest.
// Depends on nca_pkg.
module nca_front import nca_pkg::*; #(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  cluster_sel,
  input  logic [3:0]  feature_sel,
  input  logic signed [15:0] value,
  input  logic        value_ok,
  input  logic        last_feature,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t             cmd;
  logic             keep;
  logic             csel_ok;
  logic             fsel_ok;
  logic             push;
  cmd_t             q_mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic [QAW:0]     count_next;

  always_comb begin
    csel_ok    = 9'(cluster_sel) < 9'(MAX_CLUSTERS);
    fsel_ok    = 9'(feature_sel) < 9'(MAX_FEATURES);
    cmd.kind   = op;
    cmd.csel   = IDX_W'(cluster_sel);
    cmd.fsel   = IDX_W'(feature_sel);
    cmd.value  = value;
    cmd.add    = value_ok && fsel_ok;
    cmd.last   = last_feature;
    unique case (op)
      OP_LOAD:  keep = csel_ok && fsel_ok;
      OP_POINT: keep = cmd.add || last_feature;
      OP_CLEAR: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign in_ready = count != (QAW+1)'(QDEPTH);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = count != '0;
  assign q_cmd    = q_mem[rd_ptr];

  always_comb begin
    count_next = count;
    priority if (push && !q_pop) begin
      count_next = count + 1'b1;
    end else if (q_pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd;
    end
  end

endmodule

// File: rtl/core/nca_back.sv
// Back end: centroid store, per-cluster distance pass, argmin and running sum.
// Depends on nca_pkg; fed by the command queue in nca_front.
module nca_back import nca_pkg::*; #(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CFG_W-1:0]  active_clusters,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        best_cluster,
  output logic [ACC_W-1:0]  min_distance,
  output logic [WCSS_W-1:0] total_wcss
);

  localparam int CW     = $clog2(MAX_CLUSTERS);
  localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CDEPTH = 1 << (CW + FW);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic [CW-1:0]           j;
  logic [CW-1:0]           lastj;
  logic [8:0]              act9;
  logic [FW-1:0]           cur_f;
  logic signed [VAL_W-1:0] cur_x;
  logic                    cur_add;
  logic                    cur_last;

  logic [VAL_W-1:0]        cmem [CDEPTH];
  logic [ACC_W-1:0]        acc_mem [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] acc_vld;

  logic                    s1_vld;
  logic [CW-1:0]           s1_j;
  logic [VAL_W-1:0]        c_rd;
  logic [ACC_W-1:0]        a_rd;
  logic                    v_rd;
  logic                    s2_vld;
  logic [CW-1:0]           s2_j;
  logic [31:0]             s2_sq;
  logic [ACC_W-1:0]        s2_acc;

  logic signed [VAL_W:0]   diff;
  logic signed [2*VAL_W+1:0] sq_full;
  logic [ACC_W:0]          sum;
  logic [ACC_W-1:0]        sat;
  logic [CW-1:0]           best;
  logic [ACC_W-1:0]        bestd;
  logic [WCSS_W-1:0]       wcss;
  logic [WCSS_W:0]         wsum;
  logic [WCSS_W-1:0]       wsat;
  logic                    finish_fire;

  // Last cluster index of the pass, with the active count clamped to range.
  always_comb begin
    act9 = 9'(active_clusters);
    priority if (act9 == 9'd0) begin
      lastj = '0;
    end else if (act9 > 9'(MAX_CLUSTERS)) begin
      lastj = CW'(MAX_CLUSTERS - 1);
    end else begin
      lastj = CW'(act9 - 9'd1);
    end
  end

  assign q_pop       = (state == S_IDLE) && q_valid;
  assign finish_fire = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_pop && q_cmd.kind == OP_POINT) state_next = S_RUN;
      end
      S_RUN: begin
        if (j == lastj) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!s1_vld && !s2_vld) state_next = cur_last ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (finish_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Stage B: difference and square of the centroid read.
  always_comb begin
    diff    = {cur_x[VAL_W-1], cur_x} - {c_rd[VAL_W-1], c_rd};
    sq_full = diff * diff;
  end

  // Stage C: saturating accumulate.
  always_comb begin
    sum  = (ACC_W+1)'(s2_acc) + (ACC_W+1)'(s2_sq);
    sat  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    wsum = (WCSS_W+1)'(wcss) + (WCSS_W+1)'(bestd);
    wsat = wsum[WCSS_W] ? {WCSS_W{1'b1}} : wsum[WCSS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      j         <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      wcss      <= '0;
      acc_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      s1_vld <= (state == S_RUN);
      s2_vld <= s1_vld;
      if (state == S_RUN) begin
        j <= j + 1'b1;
      end else begin
        j <= '0;
      end
      if (q_pop && q_cmd.kind == OP_CLEAR) begin
        wcss <= '0;
      end else if (finish_fire) begin
        wcss <= wsat;
      end
      // Drop all accumulators when a point completes.
      if (finish_fire) begin
        acc_vld <= '0;
      end else if (s2_vld) begin
        acc_vld[s2_j] <= 1'b1;
      end
      if (finish_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == OP_POINT) begin
      cur_f    <= q_cmd.fsel[FW-1:0];
      cur_x    <= q_cmd.value;
      cur_add  <= q_cmd.add;
      cur_last <= q_cmd.last;
    end
    s1_j   <= j;
    v_rd   <= acc_vld[j];
    s2_j   <= s1_j;
    s2_sq  <= cur_add ? sq_full[31:0] : 32'd0;
    s2_acc <= v_rd ? a_rd : '0;
    // Scan ascending; ties move the pick to the higher index.
    if (s2_vld && cur_last) begin
      if (s2_j == '0 || sat <= bestd) begin
        best  <= s2_j;
        bestd <= sat;
      end
    end
    if (finish_fire) begin
      best_cluster <= 4'(best);
      min_distance <= bestd;
      total_wcss   <= wsat;
    end
  end

  // Centroid store.
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == OP_LOAD) begin
      cmem[{q_cmd.csel[CW-1:0], q_cmd.fsel[FW-1:0]}] <= q_cmd.value;
    end
    c_rd <= cmem[{j, cur_f}];
  end

  // Distance accumulators.
  always_ff @(posedge clk) begin
    if (s2_vld) begin
      acc_mem[s2_j] <= sat;
    end
    a_rd <= acc_mem[j];
  end

endmodule

// File: rtl/core/nearest_centroid_assign_top.sv
// Nearest-centroid assignment: top level with the cluster-count register.
// Depends on nca_pkg, nca_front and nca_back.
//
// Input channel (in_valid/in_ready): one request per handshake. A load request
// writes one centroid feature, a point request carries one feature of a point,
// a clear request zeroes the running sum. Requests pass through a two-entry
// queue, so in_ready stays high while the back end works, until it fills.
// Output channel (out_valid/out_ready): one result per point, on its last
// feature: nearest cluster, its squared distance and the running sum.
// Load and clear requests are carried out as the back end pops them from the
// queue. With k the active count clamped to 1..MAX_CLUSTERS, a point feature
// holds the back end for the pop from the queue, one pass over the k clusters
// through the centroid and accumulator memory ports, then a drain of the
// stage B and C registers. The last feature adds a finish step that publishes
// the result to the output registers, waiting first while the receiver stalls.
// Reset clears the accumulators, the running sum and the queue and sets
// active_clusters to 16; the centroid store holds garbage until loaded.
// When the receiver stalls, the result holds in the output register, the back
// end waits with the next result, and the queue then fills.
module nearest_centroid_assign_top import nca_pkg::*; #(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [3:0]        cluster_sel,
  input  logic [3:0]        feature_sel,
  input  logic signed [15:0] value,
  input  logic              value_ok,
  input  logic              last_feature,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        best_cluster,
  output logic [ACC_W-1:0]  min_distance,
  output logic [WCSS_W-1:0] total_wcss
);

  logic [CFG_W-1:0] active_clusters;
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_clusters <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_clusters <= cfg_wdata;
    end
  end

  nca_front #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .cluster_sel  (cluster_sel),
    .feature_sel  (feature_sel),
    .value        (value),
    .value_ok     (value_ok),
    .last_feature (last_feature),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  nca_back #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .active_clusters (active_clusters),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .best_cluster    (best_cluster),
    .min_distance    (min_distance),
    .total_wcss      (total_wcss)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_sum_covers_distance: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> 64'(min_distance) <= 64'(total_wcss))
    else $error("running sum below the distance just added");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");
`endif

endmodule
